### src/wllgs_pkg.sv
// Shared types, constants and codes for the weighted least-loaded group selector.
// No dependencies; used by every module under src.
package wllgs_pkg;

  // Number of groups tracked (1..8).
  localparam int unsigned GROUPS = 4;
  localparam int unsigned IDX_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  localparam int unsigned CNT_W  = 16;
  localparam int unsigned CAP_W  = 8;
  localparam int unsigned PROD_W = CNT_W + CAP_W;
  localparam int unsigned GI_W   = 3;
  localparam int unsigned ST_W   = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Request commands.
  localparam logic CMD_BIND   = 1'b0;
  localparam logic CMD_UNBIND = 1'b1;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_CPU    = 3'd1;
  localparam logic [ST_W-1:0] ST_BAD_INDEX = 3'd2;
  localparam logic [ST_W-1:0] ST_DISABLED  = 3'd3;
  localparam logic [ST_W-1:0] ST_LIMIT     = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CAPS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_BIND_UPD,
    S_UNBIND
  } state_t;

  // Write/clear control for the count bank.
  typedef struct packed {
    logic             clear;
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [CNT_W-1:0] data;
  } cnt_wr_t;

endpackage

### src/wllgs_ratio_cmp.sv
// Shared ratio comparator: registers a_cnt*a_cap and b_cnt*b_cap, then
// reports a strict less-than in the cycle after. Depends on wllgs_pkg.
module wllgs_ratio_cmp (
  input  logic                          clk,
  input  logic [wllgs_pkg::CNT_W-1:0]   a_cnt,
  input  logic [wllgs_pkg::CAP_W-1:0]   a_cap,
  input  logic [wllgs_pkg::CNT_W-1:0]   b_cnt,
  input  logic [wllgs_pkg::CAP_W-1:0]   b_cap,
  output logic                          lt
);

  logic [wllgs_pkg::PROD_W-1:0] prod_a_r;
  logic [wllgs_pkg::PROD_W-1:0] prod_b_r;

  always_ff @(posedge clk) begin
    prod_a_r <= wllgs_pkg::PROD_W'(a_cnt) * wllgs_pkg::PROD_W'(a_cap);
    prod_b_r <= wllgs_pkg::PROD_W'(b_cnt) * wllgs_pkg::PROD_W'(b_cap);
  end

  assign lt = (prod_a_r < prod_b_r);

endmodule

### src/wllgs_count_bank.sv
// Per-group assignment counters with one read port, one write port and a
// whole-bank clear. Depends on wllgs_pkg.
module wllgs_count_bank (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wllgs_pkg::cnt_wr_t            wr,
  input  logic [wllgs_pkg::IDX_W-1:0]   rd_addr,
  output logic [wllgs_pkg::CNT_W-1:0]   rd_data
);

  logic [wllgs_pkg::CNT_W-1:0] counts_r [wllgs_pkg::GROUPS];

  always_ff @(posedge clk) begin
    if (!rst_n || wr.clear) begin
      for (int i = 0; i < wllgs_pkg::GROUPS; i++) begin
        counts_r[i] <= '0;
      end
    end else if (wr.we) begin
      counts_r[wr.addr] <= wr.data;
    end
  end

  assign rd_data = counts_r[rd_addr];

endmodule

### src/weighted_least_loaded_group_select.sv
// Top level of the weighted least-loaded group selector: request FSM, config
// registers and result register. Depends on wllgs_pkg, wllgs_ratio_cmp, wllgs_count_bank.
//
//  channel   | ports                                  | handshake
//  ----------+----------------------------------------+-------------------------------
//  request   | in_cmd, in_group_index                 | start & !busy
//  result    | out_chosen_group, out_status           | out_strobe, one cycle, no stall
//  config    | cfg_index, cfg_data                    | cfg_valid & cfg_ready
//
// Sequencing: a disabled request gives its result in the cycle after it is accepted.
// An unbind passes through S_UNBIND, which reads the count, writes the update and the
// result. A bind walks the groups in index order through the shared ratio comparator:
// S_SCAN per group, plus S_CMP per group with nonzero capacity once a candidate exists,
// then S_BIND_UPD writes the update and the result. busy is high meanwhile.
// Reset (rst_n low, synchronous) clears counts, capacities and the enable flag.
// Results cannot be stalled; cfg_ready is always high.
module weighted_least_loaded_group_select (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_cmd,
  input  logic [wllgs_pkg::GI_W-1:0]         in_group_index,
  // result channel
  output logic                               out_strobe,
  output logic [wllgs_pkg::GI_W-1:0]         out_chosen_group,
  output logic [wllgs_pkg::ST_W-1:0]         out_status,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wllgs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wllgs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned IDX_W = wllgs_pkg::IDX_W;
  localparam int unsigned CNT_W = wllgs_pkg::CNT_W;
  localparam int unsigned CAP_W = wllgs_pkg::CAP_W;
  localparam int unsigned GI_W  = wllgs_pkg::GI_W;
  localparam int unsigned ST_W  = wllgs_pkg::ST_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(wllgs_pkg::GROUPS - 1);

  // ---------------- configuration registers ----------------
  logic [wllgs_pkg::CFG_DATA_W-1:0] caps_r;
  logic                             enabled_r;
  logic                             cfg_fire;
  logic                             cfg_clear;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  // Only writes to a defined register clear the counts.
  assign cfg_clear = cfg_fire &&
                     (cfg_index == wllgs_pkg::REG_CAPS || cfg_index == wllgs_pkg::REG_ENABLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      caps_r    <= '0;
      enabled_r <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_index)
        wllgs_pkg::REG_CAPS:   caps_r    <= cfg_data;
        wllgs_pkg::REG_ENABLE: enabled_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer state ----------------
  wllgs_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;          // scan index / unbind target
  logic [GI_W-1:0]   gi_r, gi_nxt;            // echoed group index
  logic              bad_r, bad_nxt;          // unbind index out of range
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [CNT_W-1:0]  best_cnt_r, best_cnt_nxt;
  logic [CAP_W-1:0]  best_cap_r, best_cap_nxt;

  logic              out_strobe_r, out_strobe_nxt;
  logic [GI_W-1:0]   out_chosen_r, out_chosen_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;

  // ---------------- datapath hookups ----------------
  wllgs_pkg::cnt_wr_t cnt_wr;
  logic [CNT_W-1:0]   rd_cnt;
  logic [CAP_W-1:0]   cur_cap;
  logic               ratio_lt;
  logic               accept;
  logic               last;

  // Capacity of the group under the scan index.
  assign cur_cap = caps_r[8 * GI_W'(idx_r) +: CAP_W];
  assign last    = (idx_r == LAST_IDX);
  assign accept  = start && !busy;

  wllgs_count_bank u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (cnt_wr),
    .rd_addr (idx_r),
    .rd_data (rd_cnt)
  );

  // cnt[idx]*cap[best] < cnt[best]*cap[idx]; result valid in S_CMP.
  wllgs_ratio_cmp u_cmp (
    .clk   (clk),
    .a_cnt (rd_cnt),
    .a_cap (best_cap_r),
    .b_cnt (best_cnt_r),
    .b_cap (cur_cap),
    .lt    (ratio_lt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wllgs_pkg::S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    gi_r         <= gi_nxt;
    bad_r        <= bad_nxt;
    found_r      <= found_nxt;
    best_idx_r   <= best_idx_nxt;
    best_cnt_r   <= best_cnt_nxt;
    best_cap_r   <= best_cap_nxt;
    out_chosen_r <= out_chosen_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    gi_nxt         = gi_r;
    bad_nxt        = bad_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_cnt_nxt   = best_cnt_r;
    best_cap_nxt   = best_cap_r;
    out_strobe_nxt = 1'b0;
    out_chosen_nxt = out_chosen_r;
    out_status_nxt = out_status_r;
    cnt_wr         = '0;
    cnt_wr.clear   = cfg_clear;

    case (state_r)
      wllgs_pkg::S_IDLE: begin
        if (accept) begin
          gi_nxt = in_group_index;
          if (!enabled_r) begin
            // pass-through: nothing recorded
            out_strobe_nxt = 1'b1;
            out_status_nxt = wllgs_pkg::ST_DISABLED;
            out_chosen_nxt = (in_cmd == wllgs_pkg::CMD_UNBIND) ? in_group_index : '0;
          end else if (in_cmd == wllgs_pkg::CMD_UNBIND) begin
            idx_nxt   = IDX_W'(in_group_index);
            bad_nxt   = ({1'b0, in_group_index} >= (GI_W + 1)'(wllgs_pkg::GROUPS));
            state_nxt = wllgs_pkg::S_UNBIND;
          end else begin
            idx_nxt      = '0;
            found_nxt    = 1'b0;
            best_idx_nxt = '0;
            state_nxt    = wllgs_pkg::S_SCAN;
          end
        end
      end

      wllgs_pkg::S_SCAN: begin
        if (cur_cap != '0 && found_r) begin
          // operands go to the comparator; decision next cycle
          state_nxt = wllgs_pkg::S_CMP;
        end else begin
          if (cur_cap != '0) begin
            found_nxt    = 1'b1;
            best_idx_nxt = idx_r;
            best_cnt_nxt = rd_cnt;
            best_cap_nxt = cur_cap;
          end
          if (last) begin
            state_nxt = wllgs_pkg::S_BIND_UPD;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end

      wllgs_pkg::S_CMP: begin
        if (ratio_lt) begin
          best_idx_nxt = idx_r;
          best_cnt_nxt = rd_cnt;
          best_cap_nxt = cur_cap;
        end
        if (last) begin
          state_nxt = wllgs_pkg::S_BIND_UPD;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = wllgs_pkg::S_SCAN;
        end
      end

      wllgs_pkg::S_BIND_UPD: begin
        out_strobe_nxt = 1'b1;
        state_nxt      = wllgs_pkg::S_IDLE;
        if (!found_r) begin
          out_chosen_nxt = '0;
          out_status_nxt = wllgs_pkg::ST_NO_CPU;
        end else begin
          out_chosen_nxt = GI_W'(best_idx_r);
          if (best_cnt_r == wllgs_pkg::COUNT_MAX) begin
            out_status_nxt = wllgs_pkg::ST_LIMIT;
          end else begin
            out_status_nxt = wllgs_pkg::ST_OK;
            cnt_wr.we      = 1'b1;
            cnt_wr.addr    = best_idx_r;
            cnt_wr.data    = best_cnt_r + 1'b1;
          end
        end
      end

      wllgs_pkg::S_UNBIND: begin
        out_strobe_nxt = 1'b1;
        out_chosen_nxt = gi_r;
        state_nxt      = wllgs_pkg::S_IDLE;
        if (bad_r) begin
          out_status_nxt = wllgs_pkg::ST_BAD_INDEX;
        end else if (rd_cnt == '0) begin
          out_status_nxt = wllgs_pkg::ST_LIMIT;
        end else begin
          out_status_nxt = wllgs_pkg::ST_OK;
          cnt_wr.we      = 1'b1;
          cnt_wr.addr    = idx_r;
          cnt_wr.data    = rd_cnt - 1'b1;
        end
      end

      default: begin
        state_nxt = wllgs_pkg::S_IDLE;
      end
    endcase
  end

  assign busy             = (state_r != wllgs_pkg::S_IDLE);
  assign out_strobe       = out_strobe_r;
  assign out_chosen_group = out_chosen_r;
  assign out_status       = out_status_r;

endmodule

### test/wllgs_checker.sv
// Placement checker for the weighted least-loaded group selector: snoops the request,
// result and configuration channels, predicts each result and compares it.
// Depends on wllgs_pkg for widths, commands, status codes and register indexes.
module wllgs_checker
  import wllgs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  in_cmd,
  input  logic [GI_W-1:0]       in_group_index,
  input  logic                  out_strobe,
  input  logic [GI_W-1:0]       out_chosen_group,
  input  logic [ST_W-1:0]       out_status,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [GI_W-1:0] group;
    logic [ST_W-1:0] status;
  } placement_t;

  logic [CFG_DATA_W-1:0] caps_reg;
  logic                  track_en;
  logic [CNT_W-1:0]      load_count [GROUPS];
  placement_t            placement_q [$];
  int                    shown;

  // Works out the result of one request and updates the shadow counts.
  function automatic placement_t place_request(input logic cmd, input logic [GI_W-1:0] gi);
    placement_t       r;
    logic             found;
    int               best;
    logic [CAP_W-1:0] cap;
    logic [CAP_W-1:0] best_cap;
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs;
    r.group  = '0;
    r.status = ST_OK;
    found    = 1'b0;
    best     = 0;
    best_cap = '0;
    if (!track_en) begin
      r.status = ST_DISABLED;
      if (cmd == CMD_UNBIND) r.group = gi;
    end else if (cmd == CMD_BIND) begin
      for (int g = 0; g < GROUPS; g++) begin
        cap = caps_reg[8*g +: 8];
        lhs = load_count[g] * best_cap;
        rhs = load_count[best] * cap;
        if (cap != '0 && (!found || lhs < rhs)) begin
          best     = g;
          best_cap = cap;
          found    = 1'b1;
        end
      end
      if (!found) begin
        r.status = ST_NO_CPU;
      end else begin
        r.group = GI_W'(best);
        if (load_count[best] == COUNT_MAX) r.status = ST_LIMIT;
        else load_count[best] = load_count[best] + 1'b1;
      end
    end else begin
      r.group = gi;
      if (int'(gi) >= GROUPS) r.status = ST_BAD_INDEX;
      else if (load_count[int'(gi)] == '0) r.status = ST_LIMIT;
      else load_count[int'(gi)] = load_count[int'(gi)] - 1'b1;
    end
    return r;
  endfunction

  task automatic note_fault(input string what, input placement_t want);
    fail_count++;
    if (shown < 10) begin
      shown++;
      $display("[%0t] %s: expected group %0d status %0d, got group %0d status %0d",
               $time, what, want.group, want.status, out_chosen_group, out_status);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      caps_reg   = '0;
      track_en   = 1'b0;
      foreach (load_count[g]) load_count[g] = '0;
      placement_q.delete();
      fail_count = 0;
      shown      = 0;
    end else begin
      if (out_strobe) begin
        if (placement_q.size() == 0) begin
          note_fault("result with no request outstanding", '0);
        end else if (placement_q[0] !== {out_chosen_group, out_status}) begin
          note_fault("placement mismatch", placement_q.pop_front());
        end else begin
          void'(placement_q.pop_front());
        end
      end
      // Either register write wipes the counts; spare indexes do nothing.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CAPS: begin
            caps_reg = cfg_data;
            foreach (load_count[g]) load_count[g] = '0;
          end
          REG_ENABLE: begin
            track_en = cfg_data[0];
            foreach (load_count[g]) load_count[g] = '0;
          end
          default: ;
        endcase
      end
      if (start && !busy) placement_q.push_back(place_request(in_cmd, in_group_index));
    end
    pending = placement_q.size();
  end

endmodule

### test/weighted_least_loaded_group_select_tb.sv
// Testbench top for weighted_least_loaded_group_select: clock, reset, request and
// register-write stimulus, watchdog and verdict. Depends on wllgs_pkg and wllgs_checker.
module weighted_least_loaded_group_select_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wllgs_pkg::*;

  // Register indexes past the last real register: writes must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Cycles without any handshake before the run is declared hung. Binds and sender
  // gaps (geometric and short) stay well below this, so it is ample.
  localparam int HANG_LIMIT = 2000;

  localparam int PHASES     = 8;
  localparam int PHASE_REQS = 225;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_cmd;
  logic [GI_W-1:0]       in_group_index;
  logic                  out_strobe;
  logic [GI_W-1:0]       out_chosen_group;
  logic [ST_W-1:0]       out_status;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int gap_pct;
  int hang_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  weighted_least_loaded_group_select dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_group_index   (in_group_index),
    .out_strobe       (out_strobe),
    .out_chosen_group (out_chosen_group),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  wllgs_checker placement_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_group_index   (in_group_index),
    .out_strobe       (out_strobe),
    .out_chosen_group (out_chosen_group),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Watchdog: any accepted request, result or register write resets the count.
  always @(posedge clk) begin
    if (!rst_n) begin
      hang_cycles <= 0;
    end else if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      hang_cycles <= 0;
    end else if (hang_cycles >= HANG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      hang_cycles <= hang_cycles + 1;
    end
  end

  // One request. Random idle cycles go first (start low), then start is held
  // with the payload until a rising edge finds busy low. start is never lowered
  // after acceptance inside this task, so back-to-back requests keep it high.
  task automatic send_request(input logic cmd, input logic [GI_W-1:0] gi);
    logic taken;
    taken = 1'b0;
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start          <= 1'b1;
    in_cmd         <= cmd;
    in_group_index <= gi;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
      if (!taken) @(negedge clk);
    end
  endtask

  // Drop start and hold off until every request has its result and the block is idle.
  task automatic wait_quiet();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
  endtask

  // Register write; callers make sure the block is quiet first.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] caps;
    logic [CFG_DATA_W-1:0] en_word;
    logic                  cmd;
    logic [GI_W-1:0]       gi;

    rst_n          = 1'b0;
    start          = 1'b0;
    in_cmd         = CMD_BIND;
    in_group_index = '0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_CAPS;
    cfg_data       = '0;
    gap_pct        = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- Directed ----
    // Out of reset tracking is off: everything reports disabled, unbind echoes.
    send_request(CMD_BIND, 3'd5);
    send_request(CMD_UNBIND, 3'd7);
    send_request(CMD_UNBIND, 3'd0);
    wait_quiet();

    // Tracking on with every capacity zero: bind has nowhere to go, unbind of an
    // empty group is refused, and indexes past the last group are bad.
    write_reg(REG_ENABLE, 64'd1);
    send_request(CMD_BIND, 3'd0);
    send_request(CMD_UNBIND, 3'd0);
    send_request(CMD_UNBIND, 3'(GROUPS));
    send_request(CMD_UNBIND, 3'd7);
    wait_quiet();

    // Capacities 3, 1, 0, 255 with junk in the unused upper bytes. Six binds walk
    // the ratio order; group 2 has no CPUs so unbinding it hits an empty count.
    write_reg(REG_CAPS, 64'h5A5A_5A5A_FF00_0103);
    repeat (6) send_request(CMD_BIND, 3'd7);
    send_request(CMD_UNBIND, 3'd2);
    send_request(CMD_UNBIND, 3'd3);
    send_request(CMD_UNBIND, 3'd1);
    wait_quiet();

    // Spare register indexes must neither take effect nor clear the counts.
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '1);
    send_request(CMD_UNBIND, 3'd0);
    wait_quiet();

    // Disable, then re-enable with every capacity at the maximum: equal ratios,
    // so the lowest index wins each tie.
    write_reg(REG_ENABLE, 64'hFFFF_FFFF_FFFF_FFFE);
    send_request(CMD_BIND, 3'd0);
    send_request(CMD_UNBIND, 3'd5);
    wait_quiet();
    write_reg(REG_ENABLE, 64'd1);
    write_reg(REG_CAPS, '1);
    repeat (4) send_request(CMD_BIND, 3'd0);
    send_request(CMD_UNBIND, 3'd6);
    wait_quiet();

    // ---- Random phases ----
    // Each phase picks fresh capacities (zero, one, max or random per group, now and
    // then no CPUs at all) and mostly enables tracking. Requests lean slightly
    // toward bind so unbinds usually find a populated group; a few unbinds use
    // any index to hit the bad-index path.
    for (int ph = 0; ph < PHASES; ph++) begin
      caps = {$urandom, $urandom};
      for (int g = 0; g < 8; g++) begin
        case ($urandom_range(3))
          0: caps[8*g +: 8] = 8'h00;
          1: caps[8*g +: 8] = 8'h01;
          2: caps[8*g +: 8] = 8'hFF;
          default: ;
        endcase
      end
      if ($urandom_range(5) == 0) caps[8*GROUPS-1:0] = '0;
      en_word    = {$urandom, $urandom};
      en_word[0] = ($urandom_range(9) != 0);
      if ($urandom_range(1)) begin
        write_reg(REG_CAPS, caps);
        write_reg(REG_ENABLE, en_word);
      end else begin
        write_reg(REG_ENABLE, en_word);
        write_reg(REG_CAPS, caps);
      end
      if ($urandom_range(2) == 0)
        write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});

      // Sender idle share rotates: none, heavy, moderate.
      case (ph % 3)
        0: gap_pct = 0;
        1: gap_pct = 57;
        default: gap_pct = 35;
      endcase

      for (int i = 0; i < PHASE_REQS; i++) begin
        cmd = ($urandom_range(99) < 55) ? CMD_BIND : CMD_UNBIND;
        if (cmd == CMD_BIND || $urandom_range(9) == 0) gi = 3'($urandom_range(7));
        else gi = 3'($urandom_range(GROUPS - 1));
        send_request(cmd, gi);
        // Odd phases stop halfway and let the pipeline run dry.
        if (ph % 2 == 1 && i == PHASE_REQS / 2) wait_quiet();
      end
      wait_quiet();
    end

    // Let any stray result show up before the verdict.
    repeat (2 * GROUPS + 8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
